### rtl/fpdv_pkg.sv
// Shared types and constants for the fixed-point divider with selectable Q format.
// No dependencies; imported by every fpdv module and the top level.
`timescale 1ns / 1ps
package fpdv_pkg;

  // (2^31-1) >> 2, numerator of the reciprocal estimate
  localparam logic [29:0] RECIP_NUM = 30'h1FFF_FFFF;
  localparam int RECIP_QW = 15;               // quotient bits of the estimate
  localparam int RECIP_BPS = 3;               // quotient bits per divider stage
  localparam int RECIP_STG = RECIP_QW / RECIP_BPS;
  localparam logic signed [7:0] SHIFT_BASE = 8'sd29;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

  // operands and shift carried along the pipeline
  typedef struct packed {
    logic signed [31:0] an;
    logic signed [31:0] bn;
    logic signed [7:0]  lsh;
    logic               dbz;
  } fpdv_ctx_t;

  // divider stage contents
  typedef struct packed {
    logic [29:0]          rem;
    logic [15:0]          d;
    logic [RECIP_QW-1:0]  q;
    logic                 neg;
    fpdv_ctx_t            ctx;
  } fpdv_div_t;

  // leading zero count of a 32-bit word, 32 for zero
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // replace the most negative value by its neighbor
  function automatic logic signed [31:0] sat_min(input logic [31:0] v);
    return (v == S32_MIN) ? (S32_MIN + 32'sd1) : $signed(v);
  endfunction

endpackage

### rtl/fpdv_norm.sv
// Operand normalization: saturate, count headroom, shift, pick the divisor top half.
// Two register stages. Depends on fpdv_pkg.
`timescale 1ns / 1ps
module fpdv_norm import fpdv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic [5:0]  result_q,
  output logic        out_vld,
  output fpdv_div_t   out_dv
);

  logic               v1_r;
  logic signed [31:0] a1_r, b1_r;
  logic [4:0]         ah1_r, bh1_r;
  logic [5:0]         q1_r;
  logic signed [31:0] a_s, b_s;
  logic [31:0]        a_mag, b_mag;
  logic [5:0]         a_lz, b_lz;
  fpdv_div_t          dv_nxt, dv_r;
  logic               v2_r;
  logic signed [31:0] an, bn;
  logic signed [15:0] top;

  always_comb begin
    a_s   = sat_min(dividend);
    b_s   = sat_min(divisor);
    a_mag = a_s[31] ? 32'(-a_s) : a_s;
    b_mag = b_s[31] ? 32'(-b_s) : b_s;
    a_lz  = lzc32(a_mag);
    b_lz  = lzc32(b_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= a_s;
      b1_r  <= b_s;
      ah1_r <= 5'(a_lz - 6'd1);
      bh1_r <= 5'(b_lz - 6'd1);
      q1_r  <= result_q;
      dv_r  <= dv_nxt;
    end
  end

  always_comb begin
    an  = a1_r <<< ah1_r;
    bn  = b1_r <<< bh1_r;
    top = bn[31:16];
    dv_nxt.rem     = RECIP_NUM;
    dv_nxt.d       = top[15] ? 16'(-top) : top;
    dv_nxt.q       = '0;
    dv_nxt.neg     = top[15];
    dv_nxt.ctx.an  = an;
    dv_nxt.ctx.bn  = bn;
    dv_nxt.ctx.lsh = SHIFT_BASE + $signed({3'b000, ah1_r}) - $signed({3'b000, bh1_r})
                     - $signed({2'b00, q1_r});
    dv_nxt.ctx.dbz = (b1_r == 32'sd0);
  end

  assign out_vld = v2_r;
  assign out_dv  = dv_r;

endmodule

### rtl/fpdv_recip.sv
// Pipelined restoring divider for the 15-bit reciprocal estimate, three bits per stage.
// Depends on fpdv_pkg.
`timescale 1ns / 1ps
module fpdv_recip import fpdv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  fpdv_div_t        in_dv,
  output logic             out_vld,
  output logic signed [15:0] inv,
  output fpdv_ctx_t        out_ctx
);

  fpdv_div_t dv_r  [RECIP_STG+1];
  logic      vld_r [RECIP_STG+1];

  assign dv_r[0]  = in_dv;
  assign vld_r[0] = in_vld;

  for (genvar k = 0; k < RECIP_STG; k++) begin : g_stg
    fpdv_div_t nxt;
    always_comb begin
      logic [29:0] sub;
      nxt = dv_r[k];
      for (int j = 0; j < RECIP_BPS; j++) begin
        sub = 30'(nxt.d) << (RECIP_QW - 1 - RECIP_BPS * k - j);
        if (nxt.rem >= sub) begin
          nxt.rem = nxt.rem - sub;
          nxt.q[RECIP_QW - 1 - RECIP_BPS * k - j] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else if (en) vld_r[k+1] <= vld_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[k+1] <= nxt;
    end
  end

  // truncation toward zero: negate the magnitude quotient
  assign inv     = dv_r[RECIP_STG].neg ? -$signed({1'b0, dv_r[RECIP_STG].q})
                                       :  $signed({1'b0, dv_r[RECIP_STG].q});
  assign out_vld = vld_r[RECIP_STG];
  assign out_ctx = dv_r[RECIP_STG].ctx;

endmodule

### rtl/fpdv_refine.sv
// First quotient, residual refinement and final Q-format shift, six register stages.
// Depends on fpdv_pkg.
`timescale 1ns / 1ps
module fpdv_refine import fpdv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [15:0] inv,
  input  fpdv_ctx_t          in_ctx,
  output logic               out_vld,
  output logic signed [31:0] quotient,
  output logic               dbz
);

  logic [5:0]         v_r;
  fpdv_ctx_t          c1_r, c2_r, c3_r, c4_r, c5_r;
  logic signed [15:0] i1_r, i2_r, i3_r;
  logic signed [47:0] p1_r, p3_r;
  logic signed [63:0] p2_r;
  logic signed [31:0] r2_r, r3_r, r4_r, res5_r, an3_r;
  logic signed [31:0] q_r, q_nxt, an3_nxt, res5_nxt;
  logic signed [31:0] t;
  logic [7:0]         nsh;
  logic [4:0]         s;
  logic signed [31:0] lo, hi, v;
  logic               dbz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[4:0], in_vld};
  end

  always_comb begin
    t        = $signed({p2_r[60:32], 3'b000});
    an3_nxt  = c2_r.an - t;
    res5_nxt = r4_r + $signed(p3_r[47:16]);
  end

  // final shift: saturating left, arithmetic right, or flush
  always_comb begin
    nsh   = 8'(-c5_r.lsh);
    s     = (nsh > 8'd31) ? 5'd31 : nsh[4:0];
    lo    = S32_MIN >>> s;
    hi    = S32_MAX >>> s;
    v     = res5_r;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (c5_r.dbz) q_nxt = '0;
    else if (c5_r.lsh < 0) q_nxt = v <<< s;
    else if (c5_r.lsh < 8'sd32) q_nxt = res5_r >>> c5_r.lsh[4:0];
    else q_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= 48'(in_ctx.an) * 48'(inv);
      c1_r   <= in_ctx;
      i1_r   <= inv;
      p2_r   <= 64'(c1_r.bn) * 64'($signed(p1_r[47:16]));
      r2_r   <= p1_r[47:16];
      c2_r   <= c1_r;
      i2_r   <= i1_r;
      an3_r  <= an3_nxt;
      r3_r   <= r2_r;
      c3_r   <= c2_r;
      i3_r   <= i2_r;
      p3_r   <= 48'(an3_r) * 48'(i3_r);
      r4_r   <= r3_r;
      c4_r   <= c3_r;
      res5_r <= res5_nxt;
      c5_r   <= c4_r;
      q_r    <= q_nxt;
      dbz_r  <= c5_r.dbz;
    end
  end

  assign out_vld  = v_r[5];
  assign quotient = q_r;
  assign dbz      = dbz_r;

endmodule

### rtl/fixed_point_divide_varq_core.sv
// Top level of the pipelined fixed-point divider with selectable result Q format.
// Depends on fpdv_pkg, fpdv_norm, fpdv_recip, fpdv_refine.
//
//   channel | direction | tdata                                   | tuser
//   in_     | slave     | [31:0] dividend [63:32] divisor [69:64] q | -
//   out_    | master    | [31:0] quotient                         | divide_by_zero
//
// One item per cycle unless out_ stalls; stages: 2 normalize, 5 reciprocal, 6 refine.
// The reciprocal divider stages and the three multiplies set the depth.
// rst_n clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
module fixed_point_divide_varq_core import fpdv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // dividend[31:0], divisor[63:32], result_q[69:64], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // quotient[31:0]
  output logic        out_tuser   // divide_by_zero
);

  logic               en;
  logic               nv, rv;
  fpdv_div_t          ndv;
  logic signed [15:0] inv;
  fpdv_ctx_t          rctx;
  logic signed [31:0] quo;

  // advance whenever the output slot is free or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  fpdv_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid && in_tready),
    .dividend(in_tdata[31:0]), .divisor(in_tdata[63:32]), .result_q(in_tdata[69:64]),
    .out_vld(nv), .out_dv(ndv)
  );

  fpdv_recip u_recip (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(nv), .in_dv(ndv),
    .out_vld(rv), .inv(inv), .out_ctx(rctx)
  );

  fpdv_refine u_refine (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(rv), .inv(inv), .in_ctx(rctx),
    .out_vld(out_tvalid), .quotient(quo), .dbz(out_tuser)
  );

  assign out_tdata = quo;

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("zero divisor with nonzero quotient");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output slot");

endmodule
